// ----- design/rbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rbs_pkg
// shared widths, register codes and reset values for the ray/box slab test
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIFF_W        = 34;
    localparam int EPS_W         = 16;
    localparam int TMAX_W        = 31;
    localparam int CFG_DATA_W    = 31;

    typedef enum logic [0:0] {
        CFG_DIR_EPSILON = 1'b0,
        CFG_T_MAX       = 1'b1
    } cfg_index_t;

    localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd1;
    localparam logic [TMAX_W-1:0] TMAX_RESET = 31'h7FFF_FFFF;

    // stages through the divider: magnitude stage, one stage per quotient bit, sign stage
    function automatic int div_lat(input int frac);
        return DIFF_W + frac + 2;
    endfunction

    typedef struct packed {
        logic               par_x;
        logic               inside_x;
        logic               par_y;
        logic               inside_y;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } side_t;

endpackage

// ----- design/rbs_if.sv -----
// ----------------------------------------------------------------------------
// rbs_in_if / rbs_out_if
// valid/ready channels for ray/box words and intersection results
// ----------------------------------------------------------------------------
interface rbs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rect_x;
    logic signed [31:0] rect_y;
    logic [30:0]        rect_w;
    logic [30:0]        rect_h;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;

    modport source (output valid, rect_x, rect_y, rect_w, rect_h, origin_x, origin_y,
                    dir_x, dir_y, input ready);
    modport sink (input valid, rect_x, rect_y, rect_w, rect_h, origin_x, origin_y,
                  dir_x, dir_y, output ready);
    modport monitor (input valid, ready, rect_x, rect_y, rect_w, rect_h, origin_x,
                     origin_y, dir_x, dir_y);
endinterface

interface rbs_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] t_enter;
    logic signed [31:0] t_exit;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;

    modport source (output valid, hit, t_enter, t_exit, contact_x, contact_y,
                    input ready);
    modport sink (input valid, hit, t_enter, t_exit, contact_x, contact_y,
                  output ready);
    modport monitor (input valid, ready, hit, t_enter, t_exit, contact_x, contact_y);
endinterface

// ----- design/rbs_div.sv -----
// ----------------------------------------------------------------------------
// rbs_div
// pipelined signed restoring divider, (num << FRAC_BITS) / den, saturated
// ----------------------------------------------------------------------------
module rbs_div #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [rbs_pkg::DIFF_W-1:0]  num,
    input  logic signed [31:0]                 den,
    output logic signed [31:0]                 quo
);
    import rbs_pkg::*;

    localparam int NW = DIFF_W + FRAC_BITS;

    logic [31:0]   rem_reg [0:NW];
    logic [NW-1:0] nq_reg  [0:NW];
    logic [31:0]   d_reg   [0:NW];
    logic          neg_reg [0:NW];
    logic signed [31:0] quo_reg;

    logic [DIFF_W-1:0] num_mag;
    logic [31:0]       den_mag;

    assign num_mag = num[DIFF_W-1] ? DIFF_W'(-num) : DIFF_W'(num);
    assign den_mag = den[31] ? 32'(-den) : 32'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= {num_mag, {FRAC_BITS{1'b0}}};
            d_reg[0]   <= den_mag;
            neg_reg[0] <= num[DIFF_W-1] ^ den[31];
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_step
        logic [32:0] trial;
        logic        ge;
        logic [32:0] diff;

        assign trial = {rem_reg[k], nq_reg[k][NW-1]};
        assign ge    = trial >= {1'b0, d_reg[k]};
        assign diff  = trial - {1'b0, d_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? diff[31:0] : trial[31:0];
                nq_reg[k+1]  <= {nq_reg[k][NW-2:0], ge};
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    logic [NW-1:0]      q;
    logic signed [31:0] quo_next;

    assign q = nq_reg[NW];

    always_comb
    begin
        if (neg_reg[NW])
        begin
            if (q > NW'(64'h8000_0000))
                quo_next = 32'sh8000_0000;
            else
                quo_next = 32'(-q[31:0]);
        end
        else
        begin
            if (q > NW'(64'h7FFF_FFFF))
                quo_next = 32'sh7FFF_FFFF;
            else
                quo_next = q[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

// ----- design/rbs_contact.sv -----
// ----------------------------------------------------------------------------
// rbs_contact
// contact coordinate origin + floor(dir * t >> FRAC_BITS), two stages
// ----------------------------------------------------------------------------
module rbs_contact #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic               hit,
    input  logic signed [31:0] org,
    input  logic signed [31:0] dir,
    input  logic signed [31:0] t,
    output logic signed [31:0] contact
);
    import rbs_pkg::*;

    logic signed [63:0] prod_reg;
    logic signed [31:0] org_reg;
    logic               hit_reg;
    logic signed [31:0] contact_reg;
    logic signed [31:0] contact_next;
    logic signed [63:0] sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 64'(dir) * 64'(t);
            org_reg  <= org;
            hit_reg  <= hit;
        end
    end

    // arithmetic shift gives floor rounding for negative products
    assign sum = 64'(org_reg) + (prod_reg >>> FRAC_BITS);

    always_comb
    begin
        if (!hit_reg)
            contact_next = '0;
        else if (sum > 64'sh7FFF_FFFF)
            contact_next = 32'sh7FFF_FFFF;
        else if (sum < -64'sh8000_0000)
            contact_next = 32'sh8000_0000;
        else
            contact_next = sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            contact_reg <= contact_next;
    end

    assign contact = contact_reg;

endmodule

// ----- design/ray_box_slab_intersection_top.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_top
// 2d slab test of a ray against an axis-aligned rectangle, fully pipelined
// ----------------------------------------------------------------------------
// registered in order: edge/numerator stage, the bit-per-stage dividers, clipping,
// the contact stages; throughput one word per cycle while the output is not stalled
// a stall at the output freezes the whole pipeline, nothing is dropped
// reset clears valid bits and loads dir_epsilon = 1, t_max = 0x7fffffff
module ray_box_slab_intersection_top #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    rbs_in_if.sink                            in,
    rbs_out_if.source                         out,
    input  logic                              cfg_we,
    input  rbs_pkg::cfg_index_t               cfg_index,
    input  logic [rbs_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rbs_pkg::*;

    localparam int DL = div_lat(FRAC_BITS);

    logic [EPS_W-1:0]  eps_reg;
    logic [TMAX_W-1:0] tmax_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= EPS_RESET;
            tmax_reg <= TMAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIR_EPSILON: eps_reg  <= cfg_data[EPS_W-1:0];
                CFG_T_MAX:       tmax_reg <= cfg_data[TMAX_W-1:0];
                default:         ;
            endcase
        end
    end

    logic adv;
    logic ve_reg;

    assign adv      = !ve_reg || out.ready;
    assign in.ready = adv;

    // stage 1: edges, numerators, parallel tests
    logic [32:0] hi_x, hi_y;
    logic [32:0] mag_x, mag_y;
    side_t       side_next;
    logic [DIFF_W-1:0] nlo_x, nhi_x, nlo_y, nhi_y;

    assign hi_x  = {in.rect_x[31], in.rect_x} + {2'b00, in.rect_w};
    assign hi_y  = {in.rect_y[31], in.rect_y} + {2'b00, in.rect_h};
    assign mag_x = in.dir_x[31] ? 33'(-{in.dir_x[31], in.dir_x}) : {in.dir_x[31], in.dir_x};
    assign mag_y = in.dir_y[31] ? 33'(-{in.dir_y[31], in.dir_y}) : {in.dir_y[31], in.dir_y};

    assign nlo_x = {{2{in.rect_x[31]}}, in.rect_x} - {{2{in.origin_x[31]}}, in.origin_x};
    assign nhi_x = {hi_x[32], hi_x} - {{2{in.origin_x[31]}}, in.origin_x};
    assign nlo_y = {{2{in.rect_y[31]}}, in.rect_y} - {{2{in.origin_y[31]}}, in.origin_y};
    assign nhi_y = {hi_y[32], hi_y} - {{2{in.origin_y[31]}}, in.origin_y};

    always_comb
    begin
        side_next.par_x    = (in.dir_x == '0) || (mag_x < {17'b0, eps_reg});
        side_next.par_y    = (in.dir_y == '0) || (mag_y < {17'b0, eps_reg});
        side_next.inside_x = !(in.origin_x < in.rect_x ||
                               $signed({in.origin_x[31], in.origin_x}) > $signed(hi_x));
        side_next.inside_y = !(in.origin_y < in.rect_y ||
                               $signed({in.origin_y[31], in.origin_y}) > $signed(hi_y));
        side_next.ox       = in.origin_x;
        side_next.oy       = in.origin_y;
        side_next.dx       = in.dir_x;
        side_next.dy       = in.dir_y;
    end

    side_t             side_reg [0:DL];
    logic              v_reg    [0:DL];
    logic [DIFF_W-1:0] nlo_x_reg, nhi_x_reg, nlo_y_reg, nhi_y_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            nlo_x_reg   <= nlo_x;
            nhi_x_reg   <= nhi_x;
            nlo_y_reg   <= nlo_y;
            nhi_y_reg   <= nhi_y;
            for (int k = 1; k <= DL; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DL; k++)
                v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in.valid;
            for (int k = 1; k <= DL; k++)
                v_reg[k] <= v_reg[k-1];
        end
    end

    logic signed [31:0] qlo_x, qhi_x, qlo_y, qhi_y;

    rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo_x (.clk(clk), .en(adv), .num(nlo_x_reg),
        .den(side_reg[0].dx), .quo(qlo_x));
    rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi_x (.clk(clk), .en(adv), .num(nhi_x_reg),
        .den(side_reg[0].dx), .quo(qhi_x));
    rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo_y (.clk(clk), .en(adv), .num(nlo_y_reg),
        .den(side_reg[0].dy), .quo(qlo_y));
    rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi_y (.clk(clk), .en(adv), .num(nhi_y_reg),
        .den(side_reg[0].dy), .quo(qhi_y));

    // interval clipping, x slab then y slab
    side_t              sd;
    logic signed [31:0] u0, u1, u0x, u1x, t1x, t2x, t1y, t2y;
    logic               okx, hit_c;

    assign sd = side_reg[DL];

    always_comb
    begin
        t1x = (qlo_x > qhi_x) ? qhi_x : qlo_x;
        t2x = (qlo_x > qhi_x) ? qlo_x : qhi_x;
        t1y = (qlo_y > qhi_y) ? qhi_y : qlo_y;
        t2y = (qlo_y > qhi_y) ? qlo_y : qhi_y;
        u0x = '0;
        u1x = {1'b0, tmax_reg};
        if (sd.par_x)
            okx = sd.inside_x;
        else
        begin
            if (t1x > u0x)
                u0x = t1x;
            if (t2x < u1x)
                u1x = t2x;
            okx = u0x <= u1x;
        end
        u0    = u0x;
        u1    = u1x;
        hit_c = okx;
        if (okx)
        begin
            if (sd.par_y)
                hit_c = sd.inside_y;
            else
            begin
                if (t1y > u0)
                    u0 = t1y;
                if (t2y < u1)
                    u1 = t2y;
                hit_c = u0 <= u1;
            end
        end
    end

    logic               hc_reg, hd_reg, he_reg;
    logic signed [31:0] u0c_reg, u1c_reg, u0d_reg, u1d_reg, u0e_reg, u1e_reg;
    logic signed [31:0] oxc_reg, oyc_reg, dxc_reg, dyc_reg;
    logic               vc_reg, vd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hc_reg  <= hit_c;
            u0c_reg <= u0;
            u1c_reg <= u1;
            oxc_reg <= sd.ox;
            oyc_reg <= sd.oy;
            dxc_reg <= sd.dx;
            dyc_reg <= sd.dy;
            hd_reg  <= hc_reg;
            u0d_reg <= u0c_reg;
            u1d_reg <= u1c_reg;
            he_reg  <= hd_reg;
            u0e_reg <= u0d_reg;
            u1e_reg <= u1d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else if (adv)
        begin
            vc_reg <= v_reg[DL];
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
        end
    end

    rbs_contact #(.FRAC_BITS(FRAC_BITS)) u_contact_x (.clk(clk), .en(adv), .hit(hc_reg),
        .org(oxc_reg), .dir(dxc_reg), .t(u0c_reg), .contact(out.contact_x));
    rbs_contact #(.FRAC_BITS(FRAC_BITS)) u_contact_y (.clk(clk), .en(adv), .hit(hc_reg),
        .org(oyc_reg), .dir(dyc_reg), .t(u0c_reg), .contact(out.contact_y));

    assign out.valid   = ve_reg;
    assign out.hit     = he_reg;
    assign out.t_enter = u0e_reg;
    assign out.t_exit  = u1e_reg;

`ifndef NO_ASSERTIONS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ve_reg && !he_reg |-> out.contact_x == 0 && out.contact_y == 0)
        else $error("contact not zero on a miss");
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        ve_reg && he_reg |-> u0e_reg <= u1e_reg)
        else $error("hit with empty interval");
    a_enter_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        ve_reg |-> !u0e_reg[31])
        else $error("entry parameter below zero");
    a_exit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ve_reg && !cfg_we |-> u1e_reg <= $signed({1'b0, tmax_reg}))
        else $error("exit parameter above t_max");
`endif

endmodule

// ----- bench/ray_box_slab_checker.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_checker
// watches the ray/box and result channels, predicts each intersection result
// from the accepted word and the current register copy, compares in order
// ----------------------------------------------------------------------------
module ray_box_slab_checker #(
    parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    rbs_in_if.monitor                      in,
    rbs_out_if.monitor                     out,
    input  logic                           cfg_we,
    input  rbs_pkg::cfg_index_t            cfg_index,
    input  logic [rbs_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             hit_count,
    output int                             result_count
);
    import rbs_pkg::*;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] t_enter;
        logic signed [31:0] t_exit;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
    } isect_t;

    isect_t          expected_q[$];
    logic [EPS_W-1:0]  eps_copy;
    logic [TMAX_W-1:0] tmax_copy;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // one axis: returns 0 when the interval dies on this axis
    function automatic bit slab_pass(input longint lo, input longint size,
                                     input longint org, input longint dir,
                                     input longint eps,
                                     inout longint u0, inout longint u1);
        longint hi;
        longint mag;
        longint t1;
        longint t2;
        longint tmp;
        hi  = lo + size;
        mag = (dir < 0) ? -dir : dir;
        if (dir == 0 || mag < eps)
            return !(org < lo || org > hi);
        t1 = clamp32(((lo - org) * (64'sd1 <<< FRAC_BITS)) / dir);
        t2 = clamp32(((hi - org) * (64'sd1 <<< FRAC_BITS)) / dir);
        if (t1 > t2)
        begin
            tmp = t1;
            t1  = t2;
            t2  = tmp;
        end
        if (t1 > u0)
            u0 = t1;
        if (t2 < u1)
            u1 = t2;
        return u0 <= u1;
    endfunction

    // floor rounding of the product shift, then saturate
    function automatic longint contact_point(input longint org, input longint dir,
                                             input longint t);
        longint p;
        p = dir * t;
        return clamp32(org + (p >>> FRAC_BITS));
    endfunction

    function automatic isect_t predict_isect(input logic signed [31:0] rx,
                                             input logic signed [31:0] ry,
                                             input logic [30:0] rw,
                                             input logic [30:0] rh,
                                             input logic signed [31:0] ox,
                                             input logic signed [31:0] oy,
                                             input logic signed [31:0] dx,
                                             input logic signed [31:0] dy);
        isect_t r;
        longint u0;
        longint u1;
        bit     ok;
        u0 = 0;
        u1 = longint'(tmax_copy);
        ok = slab_pass(rx, longint'(rw), ox, dx, longint'(eps_copy), u0, u1);
        if (ok)
            ok = slab_pass(ry, longint'(rh), oy, dy, longint'(eps_copy), u0, u1);
        r.hit       = ok;
        r.t_enter   = u0[31:0];
        r.t_exit    = u1[31:0];
        r.contact_x = ok ? contact_point(ox, dx, u0) : 32'sd0;
        r.contact_y = ok ? contact_point(oy, dy, u0) : 32'sd0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        isect_t got;
        isect_t want;
        if (!rst_n)
        begin
            eps_copy     <= EPS_RESET;
            tmax_copy    <= TMAX_RESET;
            fail_count   <= 0;
            hit_count    <= 0;
            result_count <= 0;
            pending      <= 0;
            expected_q.delete();
        end
        else
        begin
            if (in.valid && in.ready)
                expected_q.push_back(predict_isect(in.rect_x, in.rect_y, in.rect_w,
                                                   in.rect_h, in.origin_x, in.origin_y,
                                                   in.dir_x, in.dir_y));
            if (out.valid && out.ready)
            begin
                got = '{out.hit, out.t_enter, out.t_exit, out.contact_x, out.contact_y};
                result_count <= result_count + 1;
                if (got.hit)
                    hit_count <= hit_count + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: mismatch expected hit=%b te=%h tx=%h cx=%h cy=%h",
                                 $time, want.hit, want.t_enter, want.t_exit,
                                 want.contact_x, want.contact_y);
                        $display("%0t:          actual   hit=%b te=%h tx=%h cx=%h cy=%h",
                                 $time, got.hit, got.t_enter, got.t_exit,
                                 got.contact_x, got.contact_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
            if (cfg_we)
            begin
                if (cfg_index == CFG_DIR_EPSILON)
                    eps_copy <= cfg_data[EPS_W-1:0];
                else
                    tmax_copy <= cfg_data[TMAX_W-1:0];
            end
        end
    end
endmodule

// ----- bench/ray_box_slab_intersection_top_test.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_intersection_top_test
// drives ray/box words through several register settings with random gaps
// and output stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module ray_box_slab_intersection_top_test;
    import rbs_pkg::*;

    localparam int LATENCY = DIFF_W + FRAC_BITS_DEF + 6;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int fail_count;
    int pending;
    int hit_count;
    int result_count;
    int sent;

    rbs_in_if  ray_ch();
    rbs_out_if res_ch();

    ray_box_slab_intersection_top u_dut (
        .clk(clk), .rst_n(rst_n), .in(ray_ch.sink), .out(res_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ray_box_slab_checker u_check (
        .clk(clk), .rst_n(rst_n), .in(ray_ch.monitor), .out(res_ch.monitor),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .hit_count(hit_count),
        .result_count(result_count)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls, with calm stretches
    initial
    begin
        int n;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 7) == 0)
            begin
                res_ch.ready = 1'b0;
                n = gap_len();
                repeat (n) @(negedge clk);
            end
            res_ch.ready = ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'($signed($urandom_range(0, 40)) - 20);
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000);
        endcase
    endfunction

    task automatic send_word(input logic [31:0] rx, input logic [31:0] ry,
                             input logic [30:0] rw, input logic [30:0] rh,
                             input logic [31:0] ox, input logic [31:0] oy,
                             input logic [31:0] dx, input logic [31:0] dy,
                             input bit allow_gap);
        int n;
        if (allow_gap)
        begin
            n = gap_len();
            if (n > 0)
            begin
                ray_ch.valid = 1'b0;
                repeat (n) @(negedge clk);
            end
        end
        ray_ch.valid    = 1'b1;
        ray_ch.rect_x   = rx;
        ray_ch.rect_y   = ry;
        ray_ch.rect_w   = rw;
        ray_ch.rect_h   = rh;
        ray_ch.origin_x = ox;
        ray_ch.origin_y = oy;
        ray_ch.dir_x    = dx;
        ray_ch.dir_y    = dy;
        do @(posedge clk); while (!ray_ch.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_random(input bit aimed);
        logic [31:0] rx, ry, ox, oy, dx, dy;
        logic [30:0] rw, rh;
        rx = rand_word();
        ry = rand_word();
        rw = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                         : 31'($urandom_range(0, 32'h0020_0000));
        rh = ($urandom_range(0, 9) == 0) ? 31'($urandom())
                                         : 31'($urandom_range(0, 32'h0020_0000));
        ox = rand_word();
        oy = rand_word();
        dx = rand_dir();
        dy = rand_dir();
        if (aimed)
        begin
            // origin near the box and direction toward it so hits are common
            ox = rx - 32'($urandom_range(0, 32'h0010_0000));
            oy = ry + 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
            dx = 32'($urandom_range(1, 32'h0004_0000));
            dy = 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
        end
        send_word(rx, ry, rw, rh, ox, oy, dx, dy, 1'b1);
    endtask

    task automatic drain_and_write(input cfg_index_t idx, input logic [30:0] val);
        ray_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        logic [15:0] eps_set[5];
        logic [30:0] tmax_set[5];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_DIR_EPSILON;
        cfg_data = '0;
        sent = 0;
        ray_ch.valid = 1'b0;
        ray_ch.rect_x = '0; ray_ch.rect_y = '0; ray_ch.rect_w = '0; ray_ch.rect_h = '0;
        ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.dir_x = '0; ray_ch.dir_y = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: basic hit, parallel axes, zero direction, extremes, saturation
        send_word(32'h0001_0000, 32'h0001_0000, 31'h0002_0000, 31'h0002_0000,
                  32'h0, 32'h0001_8000, 32'h0001_0000, 32'h0, 1'b0);
        send_word(32'h0001_0000, 32'h0001_0000, 31'h0002_0000, 31'h0002_0000,
                  32'h0, 32'h0005_0000, 32'h0001_0000, 32'h0, 1'b0);
        send_word(32'h0001_0000, 32'h0001_0000, 31'h0002_0000, 31'h0002_0000,
                  32'h0001_0000, 32'h0003_0000, 32'h0, 32'h0, 1'b0);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001, 1'b0);
        send_word(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_word(32'hFFFF_0000, 32'hFFFF_0000, 31'h0, 31'h0,
                  32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b0);
        send_word(32'h0010_0000, 32'hFFF0_0000, 31'h0004_0000, 31'h0004_0000,
                  32'h0, 32'h0, 32'h0000_0003, 32'hFFFF_FFFD, 1'b0);
        send_word(32'hFFFF_FFFF, 32'h0, 31'h0000_0001, 31'h0000_0001,
                  32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0001, 1'b0);
        send_word(32'h0, 32'h0, 31'h0, 31'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0);

        eps_set  = '{16'd0, 16'hFFFF, 16'd1, 16'h0100, 16'd7};
        tmax_set = '{31'h7FFF_FFFF, 31'd0, 31'h0001_0000, 31'h0100_0000, 31'h7FFF_FFFF};
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_and_write(CFG_DIR_EPSILON, 31'(eps_set[ph]));
            drain_and_write(CFG_T_MAX, tmax_set[ph]);
            if (ph == 0)
                send_word(32'h0, 32'h0, 31'h0001_0000, 31'h0001_0000,
                          32'h0, 32'h0, 32'h0, 32'h0000_0001, 1'b0);
            for (int i = 0; i < 280; i++)
                send_random($urandom_range(0, 9) < 6);
        end

        ray_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        $display("sent %0d ray/box words over 5 register settings", sent);
        $display("checked %0d results, %0d hits", result_count, hit_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- ray_box_slab_intersection_top.f -----
design/rbs_pkg.sv
design/rbs_if.sv
design/rbs_div.sv
design/rbs_contact.sv
design/ray_box_slab_intersection_top.sv
bench/ray_box_slab_checker.sv
bench/ray_box_slab_intersection_top_test.sv
